### hw/rtl/wsao_pkg.sv
// Shared types, constants and register codes of the wheel speed averaging odometer.
`default_nettype none
package wsao_pkg;

    localparam int WINDOW_LEN_DEF = 8;
    localparam int COUNT_W        = 16;
    localparam int GAIN_W         = 16;
    localparam int SPEED_W        = 32;
    localparam int DIST_W         = 48;
    localparam int PROD_W         = SPEED_W + 1 + GAIN_W + 1;
    localparam int STEP_SHIFT     = 17;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 32;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_RIGHT_GAIN  = 2'd0,
        REG_LEFT_GAIN   = 2'd1,
        REG_TICK_PERIOD = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DWAIT,
        ST_DIST,
        ST_ACC
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic sum;
        logic mult;
        logic acc;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

### hw/rtl/wheel_speed_average_odometer.sv
// Top level of the wheel speed averaging odometer: stream ports, register file, core.
//
// Each input word carries one period's signed left and right encoder counts. Each count
// is scaled by its wheel's Q0.16 gain into a Q15.16 speed sample, the last WINDOW_LEN
// samples per wheel are kept (zero after reset, so the first averages include zeros),
// and the output word gives their boxcar averages, rounded toward minus infinity, plus
// a Q31.16 distance that integrates the mean speed times tick_period and clamps at the
// 48-bit limits. One output word per input word, in order. Words go through one at a
// time, in the steps take and scale, window update, average, distance multiply and
// accumulate. With a power-of-two WINDOW_LEN the average is a shift; otherwise a
// reciprocal-multiply divider computes it. A finished word sits in the output register
// while the next input word is taken; a stalled output holds the last stage only until
// the register frees. Registers (16 bits, low half of pwdata): right_gain at 0x0,
// left_gain at 0x4, tick_period at 0x8; addresses 0xC to 0xF are ignored on write and
// read as zero. Write them only while the block is idle.
`default_nettype none
module wheel_speed_average_odometer #(
    parameter int WINDOW_LEN = wsao_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // s_axis_tdata: left_count [15:0], right_count [31:16]
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [2*wsao_pkg::COUNT_W-1:0]      s_axis_tdata,
    // m_axis_tdata: left_speed [31:0], right_speed [63:32], travelled [111:64]
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [2*wsao_pkg::SPEED_W+wsao_pkg::DIST_W-1:0] m_axis_tdata,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [wsao_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [wsao_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wsao_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready
);
    import wsao_pkg::*;

    logic [GAIN_W-1:0]         r_right_gain;
    logic [GAIN_W-1:0]         r_left_gain;
    logic [GAIN_W-1:0]         r_tick_period;
    t_reg_idx                  reg_idx;
    logic                      wr_en;
    t_cmd                      cmd;
    t_stat                     stat;
    t_state                    state;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic signed [DIST_W-1:0]  travelled;

    // register file: word-aligned, index in paddr[3:2]
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_gain  <= '0;
            r_left_gain   <= '0;
            r_tick_period <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RIGHT_GAIN:  r_right_gain  <= pwdata[GAIN_W-1:0];
                REG_LEFT_GAIN:   r_left_gain   <= pwdata[GAIN_W-1:0];
                REG_TICK_PERIOD: r_tick_period <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RIGHT_GAIN:  prdata = APB_DATA_W'(r_right_gain);
            REG_LEFT_GAIN:   prdata = APB_DATA_W'(r_left_gain);
            REG_TICK_PERIOD: prdata = APB_DATA_W'(r_tick_period);
            default:         prdata = '0;
        endcase
    end

    wsao_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    wsao_dp #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_s_tvalid    (s_axis_tvalid),
        .i_left_count  (s_axis_tdata[COUNT_W-1:0]),
        .i_right_count (s_axis_tdata[2*COUNT_W-1:COUNT_W]),
        .i_left_gain   (r_left_gain),
        .i_right_gain  (r_right_gain),
        .i_tick_period (r_tick_period),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_left_speed  (left_speed),
        .o_right_speed (right_speed),
        .o_travelled   (travelled)
    );

    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = {travelled, right_speed, left_speed};

    // a taken word always moves on to the window update
    a_take_to_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state == ST_SUM))
        else $error("taken word did not advance to window update");

    // the dividers finish only while the controller waits for them
    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.div_done |-> (state == ST_DWAIT))
        else $error("divider done outside of wait state");

    // a new output word appears only after the accumulate step
    a_out_from_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(state) == ST_ACC))
        else $error("output word raised without accumulate");

endmodule
`default_nettype wire

### hw/rtl/wsao_ctrl.sv
// Sequencing state machine of the odometer: one word at a time through the datapath.
`default_nettype none
module wsao_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    input  wsao_pkg::t_stat       i_stat,
    output wsao_pkg::t_cmd        o_cmd,
    output wsao_pkg::t_state      o_state
);
    import wsao_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_s_tvalid) n_state = ST_SUM;
            ST_SUM:   n_state = ST_DWAIT;
            ST_DWAIT: if (i_stat.div_done) n_state = ST_DIST;
            ST_DIST:  n_state = ST_ACC;
            ST_ACC:   if (i_stat.out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: o_cmd.in_ready = 1'b1;
            ST_SUM:  o_cmd.sum      = 1'b1;
            ST_DIST: o_cmd.mult     = 1'b1;
            ST_ACC:  o_cmd.acc      = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

    assign o_state = r_state;

endmodule
`default_nettype wire

### hw/rtl/wsao_div.sv
// Floor division of a window sum by the window length: shift or reciprocal multiply.
`default_nettype none
module wsao_div #(
    parameter int WINDOW_LEN = wsao_pkg::WINDOW_LEN_DEF,
    parameter int SUM_W      = wsao_pkg::SPEED_W + $clog2(WINDOW_LEN)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [SUM_W-1:0]           i_sum,
    output logic                                   o_done,
    output logic signed [wsao_pkg::SPEED_W-1:0]    o_avg
);
    import wsao_pkg::*;

    localparam bit IS_POW2 = (WINDOW_LEN & (WINDOW_LEN - 1)) == 0;

    if (IS_POW2) begin : g_pow2
        localparam int SH = $clog2(WINDOW_LEN);
        logic signed [SPEED_W-1:0] r_q;
        logic                      r_done;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_q <= SPEED_W'(i_sum >>> SH);
            end
        end

        assign o_done = r_done;
        assign o_avg  = r_q;
    end else begin : g_recip
        // Split the magnitude into a high part and a 16-bit low part and divide each by
        // multiplying with a constant reciprocal; the high remainder carries into the low
        // part. Steps in order: latch, high quotient, carry remainder, low quotient.
        localparam int D_W  = $clog2(WINDOW_LEN);
        localparam int U_W  = SUM_W - 1;
        localparam int LO_W = 16;
        localparam int HI_W = U_W - LO_W;
        localparam int X_W  = (HI_W > D_W + LO_W) ? HI_W : D_W + LO_W;
        localparam int SH   = X_W + D_W;
        localparam int M_W  = X_W + 2;
        localparam int P_W  = X_W + M_W;
        localparam logic [M_W-1:0]  DIV_M = M_W'(((64'd1 << SH) + 64'(WINDOW_LEN) - 64'd1)
                                               / 64'(WINDOW_LEN));
        localparam logic [HI_W-1:0] DIV_K = HI_W'(WINDOW_LEN);

        logic [U_W-1:0]  r_u;
        logic            r_neg;
        logic [3:0]      r_ph;
        logic [X_W-1:0]  r_qh;
        logic [X_W-1:0]  r_x;
        logic [X_W-1:0]  r_ql;
        logic [X_W-1:0]  mul_in;
        logic [P_W-1:0]  prod;
        logic [X_W-1:0]  mul_q;
        logic [HI_W-1:0] qh_k;
        logic [HI_W-1:0] rem_hi;
        logic [U_W-1:0]  quo;

        // negative n: floor(n/d) = ~((~n)/d), so divide the magnitude only
        always_comb begin
            mul_in = r_ph[2] ? r_x : X_W'(r_u[U_W-1:LO_W]);
            prod   = P_W'(mul_in) * P_W'(DIV_M);
            mul_q  = X_W'(prod >> SH);
            qh_k   = HI_W'(r_qh[HI_W-1:0] * DIV_K);
            rem_hi = r_u[U_W-1:LO_W] - qh_k;
            quo    = {r_qh[HI_W-1:0], r_ql[LO_W-1:0]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ph <= '0;
            end else begin
                r_ph <= {r_ph[2:0], i_start};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_neg <= i_sum[SUM_W-1];
                r_u   <= U_W'(i_sum[SUM_W-1] ? ~i_sum : i_sum);
            end
            if (r_ph[0]) begin
                r_qh <= mul_q;
            end
            if (r_ph[1]) begin
                r_x <= X_W'({rem_hi[D_W-1:0], r_u[LO_W-1:0]});
            end
            if (r_ph[2]) begin
                r_ql <= mul_q;
            end
        end

        assign o_done = r_ph[3];
        assign o_avg  = r_neg ? ~quo[SPEED_W-1:0] : quo[SPEED_W-1:0];
    end

endmodule
`default_nettype wire

### hw/rtl/wsao_dp.sv
// Datapath: wheel samples, history shift lines, window sums, averages and distance.
`default_nettype none
module wsao_dp #(
    parameter int WINDOW_LEN = wsao_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wsao_pkg::t_cmd                           i_cmd,
    output wsao_pkg::t_stat                          o_stat,
    input  wire logic                                i_s_tvalid,
    input  wire logic signed [wsao_pkg::COUNT_W-1:0] i_left_count,
    input  wire logic signed [wsao_pkg::COUNT_W-1:0] i_right_count,
    input  wire logic [wsao_pkg::GAIN_W-1:0]         i_left_gain,
    input  wire logic [wsao_pkg::GAIN_W-1:0]         i_right_gain,
    input  wire logic [wsao_pkg::GAIN_W-1:0]         i_tick_period,
    input  wire logic                                i_m_tready,
    output logic                                     o_m_tvalid,
    output logic signed [wsao_pkg::SPEED_W-1:0]      o_left_speed,
    output logic signed [wsao_pkg::SPEED_W-1:0]      o_right_speed,
    output logic signed [wsao_pkg::DIST_W-1:0]       o_travelled
);
    import wsao_pkg::*;

    localparam int SUM_W = SPEED_W + $clog2(WINDOW_LEN);

    logic signed [SPEED_W-1:0] r_lsmp;
    logic signed [SPEED_W-1:0] r_rsmp;
    logic signed [SPEED_W-1:0] r_lhist [WINDOW_LEN];
    logic signed [SPEED_W-1:0] r_rhist [WINDOW_LEN];
    logic signed [SUM_W-1:0]   r_lsum;
    logic signed [SUM_W-1:0]   r_rsum;
    logic signed [SUM_W-1:0]   n_lsum;
    logic signed [SUM_W-1:0]   n_rsum;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [DIST_W-1:0]  r_dist;
    logic signed [DIST_W:0]    dist_raw;
    logic signed [DIST_W-1:0]  n_dist;
    logic signed [SPEED_W-1:0] lavg;
    logic signed [SPEED_W-1:0] ravg;
    logic                      ldone;
    logic                      rdone;
    logic                      r_valid;
    logic                      take;
    logic signed [PROD_W-STEP_SHIFT-1:0] step;

    assign take = i_cmd.in_ready && i_s_tvalid;

    // scale counts into samples as the word is taken
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_lsmp <= SPEED_W'(i_left_count * $signed({1'b0, i_left_gain}));
            r_rsmp <= SPEED_W'(i_right_count * $signed({1'b0, i_right_gain}));
        end
    end

    always_comb begin
        n_lsum = r_lsum - SUM_W'(r_lhist[WINDOW_LEN-1]) + SUM_W'(r_lsmp);
        n_rsum = r_rsum - SUM_W'(r_rhist[WINDOW_LEN-1]) + SUM_W'(r_rsmp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsum <= '0;
            r_rsum <= '0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_lhist[i] <= '0;
                r_rhist[i] <= '0;
            end
        end else if (i_cmd.sum) begin
            r_lsum     <= n_lsum;
            r_rsum     <= n_rsum;
            r_lhist[0] <= r_lsmp;
            r_rhist[0] <= r_rsmp;
            for (int i = 1; i < WINDOW_LEN; i++) begin
                r_lhist[i] <= r_lhist[i-1];
                r_rhist[i] <= r_rhist[i-1];
            end
        end
    end

    wsao_div #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_ldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sum),
        .i_sum   (n_lsum),
        .o_done  (ldone),
        .o_avg   (lavg)
    );

    wsao_div #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sum),
        .i_sum   (n_rsum),
        .o_done  (rdone),
        .o_avg   (ravg)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_prod <= PROD_W'((SPEED_W+1)'(lavg) + (SPEED_W+1)'(ravg))
                      * $signed({1'b0, i_tick_period});
        end
    end

    // floor shift, add, clamp at the 48-bit limits
    always_comb begin
        step     = (PROD_W-STEP_SHIFT)'(r_prod >>> STEP_SHIFT);
        dist_raw = (DIST_W+1)'(r_dist) + (DIST_W+1)'(step);
        if (dist_raw[DIST_W] != dist_raw[DIST_W-1]) begin
            n_dist = dist_raw[DIST_W] ? DIST_MIN : DIST_MAX;
        end else begin
            n_dist = dist_raw[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_dist  <= n_dist;
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            o_left_speed  <= lavg;
            o_right_speed <= ravg;
            o_travelled   <= n_dist;
        end
    end

    assign o_m_tvalid      = r_valid;
    assign o_stat.div_done = ldone && rdone;
    assign o_stat.out_free = !r_valid || i_m_tready;

endmodule
`default_nettype wire
